FILE: rtl/ace_pkg.sv
// ============================================================================
// ace_pkg
// Opcodes, decode types and the instruction decoder of the accumulator
// machine execute block.
// ============================================================================
package ace_pkg;

    // Instruction bytes
    localparam logic [7:0] OPC_ADD_IMM  = 8'h20;
    localparam logic [7:0] OPC_ADD_DIR  = 8'h60;
    localparam logic [7:0] OPC_ADD_IND  = 8'hE0;
    localparam logic [7:0] OPC_SUB_IMM  = 8'h21;
    localparam logic [7:0] OPC_SUB_DIR  = 8'h61;
    localparam logic [7:0] OPC_SUB_IND  = 8'hE1;
    localparam logic [7:0] OPC_NAND_IMM = 8'h22;
    localparam logic [7:0] OPC_NAND_DIR = 8'h62;
    localparam logic [7:0] OPC_NAND_IND = 8'hE2;
    localparam logic [7:0] OPC_LDA_IMM  = 8'h00;
    localparam logic [7:0] OPC_LDA_DIR  = 8'h40;
    localparam logic [7:0] OPC_LDA_IND  = 8'hC0;
    localparam logic [7:0] OPC_STA_DIR  = 8'h48;
    localparam logic [7:0] OPC_STA_IND  = 8'hC8;
    localparam logic [7:0] OPC_INP_DIR  = 8'h49;
    localparam logic [7:0] OPC_INP_IND  = 8'hC9;
    localparam logic [7:0] OPC_OUT_DIR  = 8'h41;
    localparam logic [7:0] OPC_OUT_IND  = 8'hC1;
    localparam logic [7:0] OPC_JMP      = 8'h10;
    localparam logic [7:0] OPC_JN       = 8'h11;
    localparam logic [7:0] OPC_JZ       = 8'h12;

    // Item actions
    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_NAND, OP_LDA, OP_STA, OP_INP,
        OP_OUT, OP_JMP, OP_JN, OP_JZ, OP_BAD
    } t_op;

    // Execution phase: how many memory reads have been issued
    typedef enum logic [1:0] {
        PH_ISSUE,
        PH_DIRECT,
        PH_INDIRECT
    } t_phase;

    typedef struct packed {
        t_op        op;
        logic [1:0] reads;   // dependent memory reads: 0, 1 or 2
        logic       wr;      // instruction writes memory
        logic       wr_dir;  // write address is the direct byte
    } t_dec;

    function automatic t_dec ace_decode(input logic [7:0] opc);
        t_dec d;
        d = '{op: OP_BAD, reads: 2'd0, wr: 1'b0, wr_dir: 1'b0};
        unique case (opc)
            OPC_ADD_IMM:  d.op = OP_ADD;
            OPC_ADD_DIR:  begin d.op = OP_ADD;  d.reads = 2'd1; end
            OPC_ADD_IND:  begin d.op = OP_ADD;  d.reads = 2'd2; end
            OPC_SUB_IMM:  d.op = OP_SUB;
            OPC_SUB_DIR:  begin d.op = OP_SUB;  d.reads = 2'd1; end
            OPC_SUB_IND:  begin d.op = OP_SUB;  d.reads = 2'd2; end
            OPC_NAND_IMM: d.op = OP_NAND;
            OPC_NAND_DIR: begin d.op = OP_NAND; d.reads = 2'd1; end
            OPC_NAND_IND: begin d.op = OP_NAND; d.reads = 2'd2; end
            OPC_LDA_IMM:  d.op = OP_LDA;
            OPC_LDA_DIR:  begin d.op = OP_LDA;  d.reads = 2'd1; end
            OPC_LDA_IND:  begin d.op = OP_LDA;  d.reads = 2'd2; end
            OPC_STA_DIR:  begin d.op = OP_STA;  d.wr = 1'b1; end
            OPC_STA_IND:  begin
                d.op = OP_STA; d.reads = 2'd1; d.wr = 1'b1; d.wr_dir = 1'b1;
            end
            OPC_INP_DIR:  begin d.op = OP_INP;  d.wr = 1'b1; end
            OPC_INP_IND:  begin
                d.op = OP_INP; d.reads = 2'd1; d.wr = 1'b1; d.wr_dir = 1'b1;
            end
            OPC_OUT_DIR:  begin d.op = OP_OUT;  d.reads = 2'd1; end
            OPC_OUT_IND:  begin d.op = OP_OUT;  d.reads = 2'd2; end
            OPC_JMP:      d.op = OP_JMP;
            OPC_JN:       d.op = OP_JN;
            OPC_JZ:       d.op = OP_JZ;
            default:      d.op = OP_BAD;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/ace_in_if.sv
// ============================================================================
// ace_in_if
// Input channel: one instruction or memory-load word.
// ============================================================================
interface ace_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] in_value;

    modport source (output valid, action, opcode, operand, in_value, input ready);
    modport sink   (input valid, action, opcode, operand, in_value, output ready);
endinterface

FILE: rtl/ace_out_if.sv
// ============================================================================
// ace_out_if
// Result channel: one word per input word.
// ============================================================================
interface ace_out_if;
    logic              valid;
    logic              ready;
    logic              out_valid;
    logic [7:0]        out_value;
    logic signed [7:0] accumulator;
    logic [7:0]        program_counter;
    logic              bad_opcode;

    modport source (output valid, out_valid, out_value, accumulator,
                    program_counter, bad_opcode, input ready);
    modport sink   (input valid, out_valid, out_value, accumulator,
                    program_counter, bad_opcode, output ready);
endinterface

FILE: rtl/ace_dmem.sv
// ============================================================================
// ace_dmem
// Data memory: one write port, one read port, registered read data.
// ============================================================================
module ace_dmem #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/accumulator_cpu_execute.sv
// ============================================================================
// accumulator_cpu_execute
// Execute stage of an 8-bit accumulator machine with a byte data memory.
// ============================================================================
//
//  channel  | dir | modport | word contents
//  ---------+-----+---------+--------------------------------------------------
//  i_in     | in  | sink    | action, opcode, operand, in_value
//  o_out    | out | source  | out_valid, out_value, accumulator,
//           |     |         | program_counter, bad_opcode
//
//  Immediate, jump, store/input direct and memory load words finish in the
//  issue phase; direct forms and indirect store/input also pass the direct
//  phase, and doubly indirect forms the indirect phase as well. The single read
//  port of the data memory sets this: each dependent read waits for RAM data.
//  Reset (i_rst_n low, synchronous) clears accumulator, program counter and
//  all handshake state; memory contents are undefined until written.
//  A new word is taken while the previous result waits in the output
//  register; execution stalls only at its final cycle if that register is
//  still full.
//
module accumulator_cpu_execute #(
    parameter int MEM_DEPTH = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ace_in_if.sink    i_in,
    ace_out_if.source o_out
);
    import ace_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Address modulo memory depth; operands are below 8 * MEM_DEPTH,
    // so three restoring subtract steps are enough.
    function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
        logic [10:0] r;
        r = {3'b000, a};
        for (int k = 2; k >= 0; k--) begin
            if (r >= 11'(MEM_DEPTH << k)) begin
                r = r - 11'(MEM_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // current word
    logic       r_busy, n_busy;
    logic       r_action;
    logic [7:0] r_opcode;
    logic [7:0] r_operand;
    logic [7:0] r_inval;

    // architectural registers
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_pc,  n_pc;

    // sequencer
    t_phase r_phase, n_phase;

    // output register
    logic              r_out_vld, n_out_vld;
    logic              r_out_ovalid;
    logic [7:0]        r_out_oval;
    logic [7:0]        r_out_acc;
    logic [7:0]        r_out_pc;
    logic              r_out_bad;

    // memory port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    t_dec       dec;
    logic [1:0] nreads;
    logic       fin, fin_fire, out_free, in_fire;
    logic [7:0] mv;        // operand value: immediate, direct or indirect
    logic       ovalid, bad;
    logic [7:0] oval;

    ace_dmem #(.DEPTH(MEM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign dec      = ace_decode(r_opcode);
    assign nreads   = (r_action == ACT_LOAD) ? 2'd0 : dec.reads;
    assign out_free = !r_out_vld || o_out.ready;
    assign fin_fire = fin && out_free;
    assign i_in.ready = !r_busy || fin_fire;
    assign in_fire  = i_in.valid && i_in.ready;

    // phase sequencer: issue reads, decide when the word finishes
    always_comb begin
        n_phase   = r_phase;
        fin       = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = wrap_addr(r_operand);
        mv        = r_operand;
        unique case (r_phase)
            PH_ISSUE: begin
                if (r_busy) begin
                    if (nreads == 2'd0) begin
                        fin = 1'b1;
                    end else begin
                        mem_re  = 1'b1;
                        n_phase = PH_DIRECT;
                    end
                end
            end
            PH_DIRECT: begin
                mv = mem_rdata;
                if (nreads == 2'd2) begin
                    mem_re    = 1'b1;
                    mem_raddr = wrap_addr(mem_rdata);
                    n_phase   = PH_INDIRECT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_INDIRECT: begin
                mv  = mem_rdata;
                fin = 1'b1;
            end
            default: begin
                n_phase = PH_ISSUE;
            end
        endcase
        if (fin_fire) begin
            n_phase = PH_ISSUE;
        end
    end

    // execute: accumulator, program counter, memory write, result
    always_comb begin
        n_acc  = r_acc;
        n_pc   = r_pc;
        ovalid = 1'b0;
        oval   = 8'd0;
        bad    = 1'b0;
        if (r_action == ACT_EXEC) begin
            unique case (dec.op)
                OP_ADD:  n_acc = r_acc + mv;
                OP_SUB:  n_acc = r_acc - mv;
                OP_NAND: n_acc = ~(r_acc & mv);
                OP_LDA:  n_acc = mv;
                OP_OUT:  begin ovalid = 1'b1; oval = mv; end
                OP_JMP:  n_pc = r_operand;
                OP_JN:   if (r_acc[7]) n_pc = r_operand;
                OP_JZ:   if (r_acc == 8'd0) n_pc = r_operand;
                OP_BAD:  bad = 1'b1;
                OP_STA, OP_INP: ;
                default: bad = 1'b1;
            endcase
        end

        // memory load action and store/input instructions
        mem_we    = fin_fire && ((r_action == ACT_LOAD) || dec.wr);
        mem_waddr = ((r_action == ACT_EXEC) && dec.wr_dir) ? wrap_addr(mem_rdata)
                                                            : wrap_addr(r_operand);
        mem_wdata = ((r_action == ACT_EXEC) && (dec.op == OP_STA)) ? r_acc : r_inval;
    end

    always_comb begin
        n_busy = r_busy;
        if (in_fire) begin
            n_busy = 1'b1;
        end else if (fin_fire) begin
            n_busy = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (fin_fire) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_phase   <= PH_ISSUE;
            r_out_vld <= 1'b0;
            r_acc     <= 8'd0;
            r_pc      <= 8'd0;
        end else begin
            r_busy    <= n_busy;
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
            if (fin_fire) begin
                r_acc <= n_acc;
                r_pc  <= n_pc;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action  <= i_in.action;
            r_opcode  <= i_in.opcode;
            r_operand <= i_in.operand;
            r_inval   <= i_in.in_value;
        end
        if (fin_fire) begin
            r_out_ovalid <= ovalid;
            r_out_oval   <= oval;
            r_out_acc    <= n_acc;
            r_out_pc     <= n_pc;
            r_out_bad    <= bad;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.out_valid       = r_out_ovalid;
    assign o_out.out_value       = r_out_oval;
    assign o_out.accumulator     = signed'(r_out_acc);
    assign o_out.program_counter = r_out_pc;
    assign o_out.bad_opcode      = r_out_bad;
endmodule
